### hdl/mtds_pkg.sv
// Shared types and constants for the multiple deadline timer scheduler.
// Holds command codes, the decoded operation and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtds_pkg;

   // Field widths fixed by the interface
   localparam int CMD_W  = 2;
   localparam int ID_W   = 4;
   localparam int TIME_W = 64;

   // Default slot count
   localparam int TIMER_SLOTS_DEF = 16;

   // Queue depths (two or more entries)
   localparam int OP_QUEUE_DEPTH  = 2;
   localparam int RSP_QUEUE_DEPTH = 4;

   // Expiry value meaning "none armed"
   localparam logic [TIME_W-1:0] NONE_ARMED = {TIME_W{1'b1}};

   // Command codes on the request side
   localparam logic [CMD_W-1:0] CMD_ARM     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CANCEL  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

   // Error codes
   localparam logic ERR_OK        = 1'b0;
   localparam logic ERR_ZERO_TIME = 1'b1;

   // Operation after classification
   typedef enum logic [1:0] {
      OP_NOP     = 2'd0,
      OP_ARM     = 2'd1,
      OP_CANCEL  = 2'd2,
      OP_ADVANCE = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic              error;
      logic [ID_W-1:0]   timer_id;
      logic [TIME_W-1:0] time_value;
   } op_type;

   typedef struct packed {
      logic              fired_valid;
      logic [ID_W-1:0]   fired_id;
      logic              last_result;
      logic [TIME_W-1:0] min_expiry;
      logic              error_code;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/mtds_front.sv
// Front end: takes request transfers, classifies the command and queues it.
// Depends on mtds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtds_front #(
   parameter int TIMER_SLOTS = mtds_pkg::TIMER_SLOTS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [mtds_pkg::CMD_W-1:0]  req_command,
   input  wire logic [mtds_pkg::ID_W-1:0]   req_timer_id,
   input  wire logic [mtds_pkg::TIME_W-1:0] req_time_value,
   output logic                             op_valid,
   output mtds_pkg::op_type                 op_data,
   input  wire logic                        op_pop
);
   import mtds_pkg::*;

   localparam int DEPTH = OP_QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   op_type          q_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   op_type          cls;
   logic            id_ok;
   logic            push_ok;
   logic            pop_ok;

   // Classify the incoming command
   always_comb begin
      id_ok          = 32'(req_timer_id) < 32'(TIMER_SLOTS);
      cls.kind       = OP_NOP;
      cls.error      = ERR_OK;
      cls.timer_id   = req_timer_id;
      cls.time_value = req_time_value;
      case (req_command)
         CMD_ARM: begin
            if (req_time_value == '0) begin
               cls.error = ERR_ZERO_TIME;
            end else if (id_ok) begin
               cls.kind = OP_ARM;
            end
         end
         CMD_CANCEL: begin
            if (id_ok) begin
               cls.kind = OP_CANCEL;
            end
         end
         CMD_ADVANCE: begin
            cls.kind = OP_ADVANCE;
         end
         default: begin
            cls.kind = OP_NOP;
         end
      endcase
   end

   // Small operation queue towards the back end
   assign req_full = (count_ff == CW'(DEPTH));
   assign op_valid = (count_ff != '0);
   assign op_data  = q_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = op_pop && op_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CW'(1);
      end else if (!push_ok && pop_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

### hdl/mtds_exec.sv
// Back end: slot expiry memory, armed bits and the scan sequencer for
// arm, cancel and advance. Depends on mtds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtds_exec #(
   parameter int TIMER_SLOTS = mtds_pkg::TIMER_SLOTS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       op_valid,
   input  wire mtds_pkg::op_type op_data,
   output logic            op_pop,
   input  wire logic       rsp_full,
   output logic            rsp_push,
   output mtds_pkg::rsp_type rsp_data
);
   import mtds_pkg::*;

   localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST = SLOT_W'(TIMER_SLOTS - 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_MIN    = 6'b000010,
      S_FSCAN  = 6'b000100,
      S_FSEEK  = 6'b001000,
      S_FPUSH  = 6'b010000,
      S_RESULT = 6'b100000
   } exec_state_type;

   exec_state_type      state_ff, state_in;
   logic [TIMER_SLOTS-1:0] armed_ff, armed_in;
   logic [TIMER_SLOTS-1:0] fire_ff, fire_in;
   logic [TIMER_SLOTS-1:0] fire_rest;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic                err_ff, err_in;
   logic [SLOT_W-1:0]   iss_idx_ff, iss_idx_in;
   logic                iss_on_ff, iss_on_in;
   logic [SLOT_W-1:0]   prc_idx_ff, prc_idx_in;
   logic                prc_vld_ff, prc_vld_in;
   logic [TIME_W-1:0]   best_ff, best_in;
   logic [TIME_W-1:0]   smin_ff, smin_in;
   logic [TIME_W-1:0]   earliest_ff, earliest_in;

   // Expiry memory and per-slot "earliest fired above" memory
   logic [TIME_W-1:0]   exp_mem [TIMER_SLOTS];
   logic [TIME_W-1:0]   exp_rd_ff;
   logic [TIME_W-1:0]   suf_mem [TIMER_SLOTS];
   logic [TIME_W-1:0]   suf_rd_ff;
   logic                exp_we, exp_re, suf_we, suf_re;
   logic [SLOT_W-1:0]   slot_sel;

   logic                rd_armed, rd_lt_best, rd_le_time, rd_lt_smin;
   logic [TIME_W-1:0]   min_cand;
   logic [TIME_W-1:0]   nxt;

   assign slot_sel   = SLOT_W'(op_data.timer_id);
   assign rd_armed   = armed_ff[prc_idx_ff];
   assign rd_lt_best = exp_rd_ff < best_ff;
   assign rd_le_time = exp_rd_ff <= time_ff;
   assign rd_lt_smin = exp_rd_ff < smin_ff;
   assign min_cand   = (rd_armed && rd_lt_best) ? exp_rd_ff : best_ff;
   assign nxt        = (suf_rd_ff < smin_ff) ? suf_rd_ff : smin_ff;

   // Fired set without the slot being reported now
   always_comb begin
      fire_rest             = fire_ff;
      fire_rest[iss_idx_ff] = 1'b0;
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      armed_in    = armed_ff;
      fire_in     = fire_ff;
      time_in     = time_ff;
      err_in      = err_ff;
      iss_idx_in  = iss_idx_ff;
      iss_on_in   = iss_on_ff;
      best_in     = best_ff;
      smin_in     = smin_ff;
      earliest_in = earliest_ff;
      op_pop      = 1'b0;
      exp_we      = 1'b0;
      exp_re      = 1'b0;
      suf_we      = 1'b0;
      suf_re      = 1'b0;
      rsp_push    = 1'b0;
      rsp_data.fired_valid = 1'b0;
      rsp_data.fired_id    = '0;
      rsp_data.last_result = 1'b1;
      rsp_data.min_expiry  = earliest_ff;
      rsp_data.error_code  = err_ff;

      case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               op_pop  = 1'b1;
               time_in = op_data.time_value;
               err_in  = op_data.error;
               case (op_data.kind)
                  OP_ARM: begin
                     exp_we             = 1'b1;
                     armed_in[slot_sel] = 1'b1;
                     iss_idx_in         = '0;
                     iss_on_in          = 1'b1;
                     best_in            = NONE_ARMED;
                     state_in           = S_MIN;
                  end
                  OP_CANCEL: begin
                     if (armed_ff[slot_sel]) begin
                        armed_in[slot_sel] = 1'b0;
                        iss_idx_in         = '0;
                        iss_on_in          = 1'b1;
                        best_in            = NONE_ARMED;
                        state_in           = S_MIN;
                     end else begin
                        state_in = S_RESULT;
                     end
                  end
                  OP_ADVANCE: begin
                     iss_idx_in = LAST;
                     iss_on_in  = 1'b1;
                     best_in    = NONE_ARMED;
                     smin_in    = NONE_ARMED;
                     fire_in    = '0;
                     state_in   = S_FSCAN;
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end

         // Ascending scan for the earliest armed expiry
         S_MIN: begin
            exp_re = iss_on_ff;
            if (iss_on_ff) begin
               if (iss_idx_ff == LAST) begin
                  iss_on_in = 1'b0;
               end else begin
                  iss_idx_in = iss_idx_ff + SLOT_W'(1);
               end
            end
            if (prc_vld_ff) begin
               best_in = min_cand;
               if (prc_idx_ff == LAST) begin
                  earliest_in = min_cand;
                  state_in    = S_RESULT;
               end
            end
         end

         // Descending scan: mark expired slots, note for each slot the
         // earliest expired slot above it, and the earliest survivor
         S_FSCAN: begin
            exp_re = iss_on_ff;
            if (iss_on_ff) begin
               if (iss_idx_ff == '0) begin
                  iss_on_in = 1'b0;
               end else begin
                  iss_idx_in = iss_idx_ff - SLOT_W'(1);
               end
            end
            if (prc_vld_ff) begin
               suf_we = 1'b1;
               if (rd_armed && rd_le_time) begin
                  fire_in[prc_idx_ff] = 1'b1;
                  if (rd_lt_best) begin
                     best_in = exp_rd_ff;
                  end
               end else if (rd_armed && rd_lt_smin) begin
                  smin_in = exp_rd_ff;
               end
               if (prc_idx_ff == '0) begin
                  if (fire_in == '0) begin
                     state_in = S_RESULT;
                  end else begin
                     iss_idx_in = '0;
                     state_in   = S_FSEEK;
                  end
               end
            end
         end

         // Step up to the next expired slot
         S_FSEEK: begin
            if (fire_ff[iss_idx_ff]) begin
               suf_re   = 1'b1;
               state_in = S_FPUSH;
            end else begin
               iss_idx_in = iss_idx_ff + SLOT_W'(1);
            end
         end

         // Report one expired slot and disarm it
         S_FPUSH: begin
            rsp_data.fired_valid = 1'b1;
            rsp_data.fired_id    = ID_W'(iss_idx_ff);
            rsp_data.last_result = (fire_rest == '0);
            rsp_data.min_expiry  = nxt;
            rsp_data.error_code  = ERR_OK;
            if (!rsp_full) begin
               rsp_push             = 1'b1;
               earliest_in          = nxt;
               armed_in[iss_idx_ff] = 1'b0;
               fire_in              = fire_rest;
               if (fire_rest == '0) begin
                  state_in = S_IDLE;
               end else begin
                  iss_idx_in = iss_idx_ff + SLOT_W'(1);
                  state_in   = S_FSEEK;
               end
            end
         end

         // Single result without a fired slot
         S_RESULT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      prc_vld_in = exp_re;
      prc_idx_in = iss_idx_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         armed_ff    <= '0;
         fire_ff     <= '0;
         iss_on_ff   <= 1'b0;
         prc_vld_ff  <= 1'b0;
         earliest_ff <= '0;
      end else begin
         state_ff    <= state_in;
         armed_ff    <= armed_in;
         fire_ff     <= fire_in;
         iss_on_ff   <= iss_on_in;
         prc_vld_ff  <= prc_vld_in;
         earliest_ff <= earliest_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      time_ff    <= time_in;
      err_ff     <= err_in;
      iss_idx_ff <= iss_idx_in;
      prc_idx_ff <= prc_idx_in;
      best_ff    <= best_in;
      smin_ff    <= smin_in;
   end

   // Expiry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (exp_we) begin
         exp_mem[slot_sel] <= op_data.time_value;
      end
      if (exp_re) begin
         exp_rd_ff <= exp_mem[iss_idx_ff];
      end
   end

   // Earliest-fired-above memory
   always_ff @(posedge clock) begin
      if (suf_we) begin
         suf_mem[prc_idx_ff] <= best_ff;
      end
      if (suf_re) begin
         suf_rd_ff <= suf_mem[iss_idx_ff];
      end
   end

endmodule

`default_nettype wire

### hdl/mtds_rsp_fifo.sv
// Result queue between the back end and the result ports.
// Depends on mtds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtds_rsp_fifo #(
   parameter int DEPTH = mtds_pkg::RSP_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire mtds_pkg::rsp_type push_data,
   output logic             full,
   output logic             empty,
   input  wire logic        pop,
   output mtds_pkg::rsp_type pop_data
);
   import mtds_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rsp_type         q_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push_ok;
   logic            pop_ok;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = q_ff[rd_ptr_ff];
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CW'(1);
      end else if (!push_ok && pop_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hdl/multi_timer_deadline_scheduler_unit.sv
// Multiple deadline timer. Arm, or cancel of an armed slot: the result follows an ascending minimum
// scan of one slot per cycle; a rejected arm, a cancel of a disarmed slot or an unused command
// goes straight to its result. Advance: a descending scan of all slots, then a single result when
// no slot expires, else one result per expired slot in ascending slot order, stepping over the
// slots in between. One operation at a time; a scanning arm or cancel holds the back end until its
// result is pushed. Sync reset disarms all, empties queues.
`timescale 1ns / 1ps
`default_nettype none

module multi_timer_deadline_scheduler_unit #(
   parameter int TIMER_SLOTS = mtds_pkg::TIMER_SLOTS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [mtds_pkg::CMD_W-1:0]  req_command,
   input  wire logic [mtds_pkg::ID_W-1:0]   req_timer_id,
   input  wire logic [mtds_pkg::TIME_W-1:0] req_time_value,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic                             rsp_fired_valid,
   output logic [mtds_pkg::ID_W-1:0]        rsp_fired_id,
   output logic                             rsp_last_result,
   output logic [mtds_pkg::TIME_W-1:0]      rsp_min_expiry,
   output logic                             rsp_error_code
);
   import mtds_pkg::*;

   logic    op_valid;
   op_type  op_data;
   logic    op_pop;
   logic    res_full;
   logic    res_push;
   rsp_type res_data;
   rsp_type out_data;

   // Request classification and operation queue
   mtds_front #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_command    (req_command),
      .req_timer_id   (req_timer_id),
      .req_time_value (req_time_value),
      .op_valid       (op_valid),
      .op_data        (op_data),
      .op_pop         (op_pop)
   );

   // Slot store and scan sequencer
   mtds_exec #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_exec (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_data  (op_data),
      .op_pop   (op_pop),
      .rsp_full (res_full),
      .rsp_push (res_push),
      .rsp_data (res_data)
   );

   // Result queue
   mtds_rsp_fifo #(
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_data  (out_data)
   );

   assign rsp_fired_valid = out_data.fired_valid;
   assign rsp_fired_id    = out_data.fired_id;
   assign rsp_last_result = out_data.last_result;
   assign rsp_min_expiry  = out_data.min_expiry;
   assign rsp_error_code  = out_data.error_code;

endmodule

`default_nettype wire

### tb/multi_timer_deadline_scheduler_unit_tb.sv
// Self-checking testbench for the multiple deadline timer scheduler.
// Predicts every result from a behavioural copy of the slot bank and checks it.
// Depends on mtds_pkg and multi_timer_deadline_scheduler_unit.
`timescale 1ns / 1ps

module multi_timer_deadline_scheduler_unit_tb;
   import mtds_pkg::*;

   localparam int SLOT_COUNT = TIMER_SLOTS_DEF;
   localparam int MAX_IDLE = 6;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 80;
   // Unused command code, must be ignored by the block
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
   localparam logic [TIME_W-1:0] ALL_ONES = {TIME_W{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [CMD_W-1:0] req_command = '0;
   logic [ID_W-1:0] req_timer_id = '0;
   logic [TIME_W-1:0] req_time_value = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic rsp_fired_valid;
   logic [ID_W-1:0] rsp_fired_id;
   logic rsp_last_result;
   logic [TIME_W-1:0] rsp_min_expiry;
   logic rsp_error_code;

   // Behavioural copy of the slot bank
   logic [TIME_W-1:0] slot_deadline [SLOT_COUNT];
   logic [TIME_W-1:0] soonest_deadline;
   rsp_type expiry_reports_q[$];
   rsp_type due_report;

   int mismatch_count = 0;
   int commands_sent = 0;
   int reports_checked = 0;
   int expiries_seen = 0;
   int cycle_count = 0;
   int pop_wait = 0;
   int rsp_hold_cycles = 0;
   bit sender_idle_on = 1'b1;
   bit receiver_idle_on = 1'b1;
   logic [TIME_W-1:0] now_us = 64'd0;

   multi_timer_deadline_scheduler_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_timer_id    (req_timer_id),
      .req_time_value  (req_time_value),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_fired_valid (rsp_fired_valid),
      .rsp_fired_id    (rsp_fired_id),
      .rsp_last_result (rsp_last_result),
      .rsp_min_expiry  (rsp_min_expiry),
      .rsp_error_code  (rsp_error_code)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expiry_reports_q.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic logic [TIME_W-1:0] earliest_armed();
      logic [TIME_W-1:0] best;
      best = NONE_ARMED;
      for (int i = 0; i < SLOT_COUNT; i++)
         if (slot_deadline[i] != '0 && slot_deadline[i] < best) best = slot_deadline[i];
      return best;
   endfunction

   // Update the slot bank for one accepted command and queue the reports it causes
   task automatic predict_timer_step(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                     input logic [TIME_W-1:0] t);
      rsp_type r;
      int last_slot;
      r = '0;
      r.last_result = 1'b1;
      r.error_code = ERR_OK;
      last_slot = -1;
      case (cmd)
         CMD_ARM: begin
            if (t == '0) begin
               r.error_code = ERR_ZERO_TIME;
            end else begin
               slot_deadline[id] = t;
               soonest_deadline = earliest_armed();
            end
         end
         CMD_CANCEL: begin
            // a disarmed slot leaves the earliest expiry untouched
            if (slot_deadline[id] != '0) begin
               slot_deadline[id] = '0;
               soonest_deadline = earliest_armed();
            end
         end
         CMD_ADVANCE: begin
            if (soonest_deadline != '0 && soonest_deadline <= t)
               for (int i = 0; i < SLOT_COUNT; i++)
                  if (slot_deadline[i] != '0 && slot_deadline[i] <= t) last_slot = i;
            for (int i = 0; i <= last_slot; i++) begin
               if (slot_deadline[i] != '0 && slot_deadline[i] <= t) begin
                  slot_deadline[i] = '0;
                  soonest_deadline = earliest_armed();
                  r.fired_valid = 1'b1;
                  r.fired_id = ID_W'(i);
                  r.last_result = (i == last_slot);
                  r.min_expiry = soonest_deadline;
                  expiry_reports_q.push_back(r);
               end
            end
         end
         default: ;
      endcase
      if (last_slot < 0) begin
         r.min_expiry = soonest_deadline;
         expiry_reports_q.push_back(r);
      end
   endtask

   // Offer one command, wait for its transfer, then predict
   task automatic send_timer_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                     input logic [TIME_W-1:0] t);
      int gap;
      gap = sender_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_command <= cmd;
      req_timer_id <= id;
      req_time_value <= t;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_timer_step(cmd, id, t);
      commands_sent++;
   endtask

   task automatic wait_results_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (expiry_reports_q.size() != 0) @(posedge clock);
   endtask

   // Receiver: draws a stall after each transfer, honours a long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_wait = 0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_pop <= 1'b0;
      end else if (rsp_pop && !rsp_empty) begin
         pop_wait = receiver_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         rsp_pop <= (pop_wait == 0);
      end else if (!rsp_pop) begin
         if (pop_wait > 0) pop_wait--;
         else rsp_pop <= 1'b1;
      end
   end

   // Result checker: compares each transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expiry_reports_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result fired=%0b id=%0d min=%0h",
                                      rsp_fired_valid, rsp_fired_id, rsp_min_expiry));
         end else begin
            due_report = expiry_reports_q.pop_front();
            if (rsp_fired_valid !== due_report.fired_valid)
               report_mismatch($sformatf("fired_valid got %0b want %0b", rsp_fired_valid,
                                         due_report.fired_valid));
            if (rsp_fired_id !== due_report.fired_id)
               report_mismatch($sformatf("fired_id got %0d want %0d", rsp_fired_id,
                                         due_report.fired_id));
            if (rsp_last_result !== due_report.last_result)
               report_mismatch($sformatf("last_result got %0b want %0b", rsp_last_result,
                                         due_report.last_result));
            if (rsp_min_expiry !== due_report.min_expiry)
               report_mismatch($sformatf("min_expiry got %0h want %0h", rsp_min_expiry,
                                         due_report.min_expiry));
            if (rsp_error_code !== due_report.error_code)
               report_mismatch($sformatf("error_code got %0b want %0b", rsp_error_code,
                                         due_report.error_code));
            if (due_report.fired_valid) expiries_seen++;
            reports_checked++;
         end
      end
   end

   // Extremes of every field, every command and each corner of the scheme
   task automatic test_directed_corners();
      send_timer_command(CMD_ADVANCE, 4'd0, 64'd100);     // nothing armed since reset
      send_timer_command(CMD_CANCEL, 4'd3, 64'd0);        // disarmed slot, no recompute
      send_timer_command(CMD_ARM, 4'd4, 64'd0);           // zero expiry rejected
      send_timer_command(CMD_RESERVED, 4'd15, ALL_ONES);  // unused command ignored
      send_timer_command(CMD_ARM, 4'd0, 64'd1);
      send_timer_command(CMD_ARM, 4'd15, ALL_ONES);       // looks like none armed
      send_timer_command(CMD_ARM, 4'd0, 64'd5);           // re-arm overwrites
      send_timer_command(CMD_ARM, 4'd7, 64'd100);
      send_timer_command(CMD_CANCEL, 4'd9, 64'd0);
      send_timer_command(CMD_ADVANCE, 4'd0, 64'd4);       // one short of the deadline
      send_timer_command(CMD_ADVANCE, 4'd0, 64'd5);       // exactly on the deadline
      send_timer_command(CMD_ADVANCE, 4'd0, 64'h7fff_ffff_ffff_ffff);
      send_timer_command(CMD_ADVANCE, 4'd0, ALL_ONES);    // all-ones slot fires
      send_timer_command(CMD_ADVANCE, 4'd0, 64'd0);
      send_timer_command(CMD_ARM, 4'd3, 64'h8000_0000_0000_0000);
      send_timer_command(CMD_ARM, 4'd12, 64'h0000_0000_ffff_ffff);
      send_timer_command(CMD_ARM, 4'd1, 64'h5555_5555_5555_5555);
      send_timer_command(CMD_ARM, 4'd14, 64'haaaa_aaaa_aaaa_aaaa);
      send_timer_command(CMD_CANCEL, 4'd12, 64'd0);
      send_timer_command(CMD_CANCEL, 4'd12, ALL_ONES);
      send_timer_command(CMD_ADVANCE, 4'd15, 64'haaaa_aaaa_aaaa_aaaa);
      send_timer_command(CMD_RESERVED, 4'd0, 64'd0);
      send_timer_command(CMD_ARM, 4'd2, 64'd1);
      send_timer_command(CMD_ADVANCE, 4'd9, 64'd1);
   endtask

   // Every slot fires on one advance, deadlines descending with slot number
   task automatic test_all_slots_fire();
      for (int i = 0; i < SLOT_COUNT; i++)
         send_timer_command(CMD_ARM, ID_W'(i), 64'd1000 + 64'(SLOT_COUNT - i));
      send_timer_command(CMD_ADVANCE, 4'd0, 64'd5000);
      wait_results_drained();
   endtask

   // Receiver holds off while the sender keeps offering, so the block stalls
   task automatic test_output_backpressure();
      sender_idle_on = 1'b0;
      rsp_hold_cycles = 300;
      for (int n = 0; n < 24; n++) begin
         if (n % 4 == 3) send_timer_command(CMD_ADVANCE, 4'd0, 64'd6000 + 64'(n * 10));
         else send_timer_command(CMD_ARM, ID_W'($urandom_range(0, SLOT_COUNT - 1)),
                                 64'd6000 + 64'($urandom_range(1, 300)));
      end
      sender_idle_on = 1'b1;
      wait_results_drained();
   endtask

   // Mostly arm/advance traffic near a running clock, some noise and wide values
   task automatic test_random_traffic(input int count);
      int pick;
      logic [TIME_W-1:0] t;
      now_us = 64'd10_000;
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) begin
            sender_idle_on = ((n / 60) % 3 != 1);
            receiver_idle_on = ((n / 60) % 3 != 2);
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) t = '0;
            else if (pick < 14) t = {$urandom, $urandom};
            else t = now_us + 64'($urandom_range(1, 2000));
            send_timer_command(CMD_ARM, ID_W'($urandom_range(0, SLOT_COUNT - 1)), t);
         end else if (pick < 65) begin
            send_timer_command(CMD_CANCEL, ID_W'($urandom_range(0, SLOT_COUNT - 1)),
                               {$urandom, $urandom});
         end else if (pick < 95) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               t = {$urandom, $urandom};
            end else if (pick < 10) begin
               t = ALL_ONES;
            end else begin
               now_us = now_us + 64'($urandom_range(0, 1500));
               t = now_us;
            end
            send_timer_command(CMD_ADVANCE, ID_W'($urandom_range(0, SLOT_COUNT - 1)), t);
         end else begin
            send_timer_command(CMD_RESERVED, ID_W'($urandom_range(0, SLOT_COUNT - 1)),
                               {$urandom, $urandom});
         end
         // occasionally let everything settle before carrying on
         if (n % 97 == 96) wait_results_drained();
      end
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) slot_deadline[i] = '0;
      soonest_deadline = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      wait_results_drained();
      test_all_slots_fire();
      test_output_backpressure();
      test_random_traffic(420);

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expiry_reports_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expiry_reports_q.size()));
      $display("run covered %0d commands and %0d checked results, %0d of them slot expiries",
               commands_sent, reports_checked, expiries_seen);
      $display("including a long receiver hold-off and an advance that fired every slot");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
